### rtl/core/cll_pkg.sv
// cll_pkg: shared constants and types for the cursor linked list block.
// Field widths, status codes, request kinds, datapath op codes and the
// condition bundle passed from the datapath to the sequencer. No dependencies.
package cll_pkg;

	// default store depth
	localparam int NODES_DEF = 16;

	// fixed field widths
	localparam int DATA_W   = 8;
	localparam int STATUS_W = 2;
	localparam int IDX_W    = 4;
	localparam int HEAD_W   = 5;

	// request kinds
	localparam logic REQ_INS = 1'b0;
	localparam logic REQ_DEL = 1'b1;

	// result status codes
	localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
	localparam logic [STATUS_W-1:0] ST_FULL     = 2'd1;
	localparam logic [STATUS_W-1:0] ST_NOTFOUND = 2'd2;

	// datapath op codes issued by the microcode
	localparam int OP_W = 3;
	localparam logic [OP_W-1:0] OP_IDLE = 3'd0;
	localparam logic [OP_W-1:0] OP_INS  = 3'd1;
	localparam logic [OP_W-1:0] OP_WALK = 3'd2;
	localparam logic [OP_W-1:0] OP_FREE = 3'd3;
	localparam logic [OP_W-1:0] OP_EMIT = 3'd4;

	// status flags the sequencer branches on
	typedef struct packed {
		logic beat_ins;
		logic beat_del;
		logic match;
		logic walk_more;
		logic out_busy;
	} cond_t;

endpackage

### rtl/core/cursor_linked_list.sv
// cursor_linked_list: node store with one linked list and a free list.
// Datapath, link and byte RAMs, driven by the microcode in cll_seq.
// Depends on cll_pkg, cll_ram, cll_seq.
//
//  channel | dir | signals                      | payload
//  s_*     | in  | s_tvalid s_tready s_tdata    | s_tdata: data_value; s_tuser: req_type
//          |     | s_tuser                      |
//  m_*     | out | m_tvalid m_tready m_tdata    | status, node_index, list_head, free_head
//
// An insert passes through the INS and DONE steps to the result register; a
// delete walks the list, then passes through FREE when the byte is found, and
// then DONE; the walk visits one list node per WALK step, at least one and at
// most NODES, and reads one node from the link and byte RAMs per cycle.
// One request is in flight at a time; s_tready is high only in the idle step,
// which the sequencer re-enters after each result before the next beat can be taken.
// A result waiting in the output register does not block the next request;
// the block stalls only when a second result is ready before the first is taken.
// Reset: empty list, all nodes on the free list; link RAM entries read as their
// reset value through per-entry valid bits, so no clearing pass is needed.
module cursor_linked_list
	import cll_pkg::*;
#(
	parameter int NODES = NODES_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [DATA_W-1:0]    s_tdata,  // [7:0] data_value
	input  logic                 s_tuser,  // [0] req_type
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [15:0]          m_tdata   // [1:0] status, [5:2] node_index,
	                                       // [10:6] list_head, [15:11] free_head
);

	localparam int IW    = $clog2(NODES);
	localparam int LW    = $clog2(NODES + 1);
	localparam int SW    = $clog2(NODES + 1);
	localparam int SLOTS = 1 << IW;
	localparam logic [LW-1:0] NULL_LINK = LW'(NODES);

	function automatic logic is_node(input logic [LW-1:0] p);
		return p < NULL_LINK;
	endfunction

	logic [OP_W-1:0] op;
	cond_t           cond;

	// list registers
	logic [LW-1:0]       ls_q, fs_q;
	logic [SLOTS-1:0]    vld_q;
	logic                rd_vld_q;
	logic [IW-1:0]       rd_addr_q;
	logic                m_tvalid_q;

	// working registers of one request
	logic [DATA_W-1:0]   val_q;
	logic [LW-1:0]       cur_q, prev_q;
	logic [SW-1:0]       steps_q;
	logic [IW-1:0]       idx_q;
	logic [STATUS_W-1:0] status_q;
	logic [15:0]         m_tdata_q;

	// RAM ports
	logic [IW-1:0]       raddr, waddr;
	logic                next_we, byte_we;
	logic [LW-1:0]       next_wdata, next_rdata, next_rd, next_dflt;
	logic [DATA_W-1:0]   byte_rdata;

	logic                beat, match, walk_more, out_load;
	logic [SW-1:0]       steps_inc;

	cll_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.cond   (cond),
		.op     (op)
	);

	cll_ram #(.WIDTH(LW), .DEPTH(NODES)) u_next_ram (
		.clk   (clk),
		.we    (next_we),
		.waddr (waddr),
		.wdata (next_wdata),
		.raddr (raddr),
		.rdata (next_rdata)
	);

	cll_ram #(.WIDTH(DATA_W), .DEPTH(NODES)) u_byte_ram (
		.clk   (clk),
		.we    (byte_we),
		.waddr (waddr),
		.wdata (val_q),
		.raddr (raddr),
		.rdata (byte_rdata)
	);

	// link read: unwritten entries read as their reset chain value
	always_comb begin
		next_dflt = (rd_addr_q == '0) ? NULL_LINK : LW'(rd_addr_q) - LW'(1);
		next_rd   = rd_vld_q ? next_rdata : next_dflt;
	end

	// handshakes and branch flags
	always_comb begin
		s_tready       = (op == OP_IDLE);
		beat           = s_tvalid && s_tready;
		steps_inc      = steps_q + SW'(1);
		match          = is_node(cur_q) && (byte_rdata == val_q);
		walk_more      = is_node(cur_q) && !match && is_node(next_rd)
		                 && (steps_inc < SW'(NODES));
		out_load       = (op == OP_EMIT) && (!m_tvalid_q || m_tready);
		cond.beat_ins  = beat && (s_tuser == REQ_INS);
		cond.beat_del  = beat && (s_tuser == REQ_DEL);
		cond.match     = match;
		cond.walk_more = walk_more;
		cond.out_busy  = m_tvalid_q && !m_tready;
	end

	// read address and write strobes per op
	always_comb begin
		raddr      = cur_q[IW-1:0];
		waddr      = cur_q[IW-1:0];
		next_we    = 1'b0;
		byte_we    = 1'b0;
		next_wdata = fs_q;
		case (op)
			OP_IDLE: begin
				raddr = (s_tuser == REQ_DEL) ? ls_q[IW-1:0] : fs_q[IW-1:0];
			end
			OP_INS: begin
				waddr      = fs_q[IW-1:0];
				next_wdata = ls_q;
				next_we    = is_node(fs_q);
				byte_we    = is_node(fs_q);
			end
			OP_WALK: begin
				raddr      = next_rd[IW-1:0];
				waddr      = prev_q[IW-1:0];
				next_wdata = next_rd;
				next_we    = match && is_node(prev_q);
			end
			OP_FREE: begin
				next_we = 1'b1;
			end
			default: begin
			end
		endcase
	end

	// list heads, valid bits and output handshake
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ls_q       <= NULL_LINK;
			fs_q       <= LW'(NODES - 1);
			vld_q      <= '0;
			rd_vld_q   <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			rd_vld_q <= vld_q[raddr];
			if (next_we) begin
				vld_q[waddr] <= 1'b1;
			end
			case (op)
				OP_INS: begin
					if (is_node(fs_q)) begin
						ls_q <= fs_q;
						fs_q <= next_rd;
					end
				end
				OP_WALK: begin
					if (match && !is_node(prev_q)) begin
						ls_q <= next_rd;
					end
				end
				OP_FREE: begin
					fs_q <= cur_q;
				end
				default: begin
				end
			endcase
			if (out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	// per-request working registers and result beat
	always_ff @(posedge clk) begin
		rd_addr_q <= raddr;
		case (op)
			OP_IDLE: begin
				if (beat) begin
					val_q    <= s_tdata;
					cur_q    <= ls_q;
					prev_q   <= NULL_LINK;
					steps_q  <= '0;
					idx_q    <= '0;
					status_q <= (s_tuser == REQ_DEL) ? ST_NOTFOUND : ST_FULL;
				end
			end
			OP_INS: begin
				if (is_node(fs_q)) begin
					idx_q    <= fs_q[IW-1:0];
					status_q <= ST_OK;
				end
			end
			OP_WALK: begin
				if (!match) begin
					prev_q  <= cur_q;
					cur_q   <= next_rd;
					steps_q <= steps_inc;
				end
			end
			OP_FREE: begin
				idx_q    <= cur_q[IW-1:0];
				status_q <= ST_OK;
			end
			default: begin
			end
		endcase
		if (out_load) begin
			m_tdata_q <= {HEAD_W'(fs_q), HEAD_W'(ls_q), IDX_W'(idx_q), status_q};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	// one request at a time
	a_single: assert property (@(posedge clk) disable iff (!arst_n)
		beat |=> !s_tready)
		else $error("request accepted while another is in flight");

	// failed requests report node index zero
	a_idx_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && (m_tdata[1:0] != ST_OK)) |-> (m_tdata[5:2] == '0))
		else $error("node index set on a failed request");

	// list and free list never share their head node
	a_heads: assert property (@(posedge clk) disable iff (!arst_n)
		!(is_node(ls_q) && (ls_q == fs_q)))
		else $error("list head equals free head");

	// walk stays within the store size
	a_walk: assert property (@(posedge clk) disable iff (!arst_n)
		(op == OP_WALK) |-> (steps_q < SW'(NODES)))
		else $error("walk ran past the node count");

endmodule

### rtl/core/cll_ram.sv
// cll_ram: generic single-write, single-read RAM with registered read data.
// Parameters set width and depth. No dependencies.
module cll_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

### rtl/core/cll_seq.sv
// cll_seq: microcode sequencer for the cursor linked list.
// A step counter indexes a read-only control table; each word issues one
// datapath op and picks the next step through two conditional jumps.
// Depends on cll_pkg.
module cll_seq
	import cll_pkg::*;
(
	input  logic            clk,
	input  logic            arst_n,
	input  cond_t           cond,
	output logic [OP_W-1:0] op
);

	localparam int STEP_W = 3;
	localparam int COND_W = 3;

	// step addresses
	localparam logic [STEP_W-1:0] S_IDLE = 3'd0;
	localparam logic [STEP_W-1:0] S_INS  = 3'd1;
	localparam logic [STEP_W-1:0] S_WALK = 3'd2;
	localparam logic [STEP_W-1:0] S_FREE = 3'd3;
	localparam logic [STEP_W-1:0] S_DONE = 3'd4;

	// jump conditions
	localparam logic [COND_W-1:0] C_NEVER     = 3'd0;
	localparam logic [COND_W-1:0] C_BEAT_INS  = 3'd1;
	localparam logic [COND_W-1:0] C_BEAT_DEL  = 3'd2;
	localparam logic [COND_W-1:0] C_MATCH     = 3'd3;
	localparam logic [COND_W-1:0] C_WALK_MORE = 3'd4;
	localparam logic [COND_W-1:0] C_OUT_BUSY  = 3'd5;

	typedef struct packed {
		logic [OP_W-1:0]   op;
		logic [COND_W-1:0] cond_a;
		logic [STEP_W-1:0] tgt_a;
		logic [COND_W-1:0] cond_b;
		logic [STEP_W-1:0] tgt_b;
		logic [STEP_W-1:0] tgt_n;
	} ctrl_t;

	// control program
	function automatic ctrl_t rom(input logic [STEP_W-1:0] pc);
		ctrl_t w;
		case (pc)
			S_IDLE:  w = '{OP_IDLE, C_BEAT_INS, S_INS, C_BEAT_DEL, S_WALK, S_IDLE};
			S_INS:   w = '{OP_INS, C_NEVER, S_DONE, C_NEVER, S_DONE, S_DONE};
			S_WALK:  w = '{OP_WALK, C_MATCH, S_FREE, C_WALK_MORE, S_WALK, S_DONE};
			S_FREE:  w = '{OP_FREE, C_NEVER, S_DONE, C_NEVER, S_DONE, S_DONE};
			S_DONE:  w = '{OP_EMIT, C_OUT_BUSY, S_DONE, C_NEVER, S_IDLE, S_IDLE};
			default: w = '{OP_IDLE, C_NEVER, S_IDLE, C_NEVER, S_IDLE, S_IDLE};
		endcase
		return w;
	endfunction

	// condition select
	function automatic logic test(input logic [COND_W-1:0] code, input cond_t c);
		logic r;
		case (code)
			C_BEAT_INS:  r = c.beat_ins;
			C_BEAT_DEL:  r = c.beat_del;
			C_MATCH:     r = c.match;
			C_WALK_MORE: r = c.walk_more;
			C_OUT_BUSY:  r = c.out_busy;
			default:     r = 1'b0;
		endcase
		return r;
	endfunction

	logic [STEP_W-1:0] pc_q;
	logic [STEP_W-1:0] pc_d;
	ctrl_t             word;

	// decode the current word and pick the next step
	always_comb begin
		word = rom(pc_q);
		op   = word.op;
		if (test(word.cond_a, cond)) begin
			pc_d = word.tgt_a;
		end else if (test(word.cond_b, cond)) begin
			pc_d = word.tgt_b;
		end else begin
			pc_d = word.tgt_n;
		end
	end

	// step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= S_IDLE;
		end else begin
			pc_q <= pc_d;
		end
	end

endmodule
